// ===== rtl/core/sle_pkg.sv =====
package sle_pkg;

   localparam int DEFAULT_CAPACITY    = 16;
   localparam int DEFAULT_VALUE_WIDTH = 16;
   localparam int REQ_TYPE_W          = 3;
   localparam int STATUS_W            = 2;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_INSERT      = 3'd0,
      OP_DELETE      = 3'd1,
      OP_SEARCH      = 3'd2,
      OP_DEL_SMALLER = 3'd3,
      OP_COUNT_RANGE = 3'd4,
      OP_LARGEST     = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CAPTURE,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_SHIFT
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SHIFT
   } ctrl_state_type;

   typedef struct packed {
      logic lt;
      logic le;
      logic eq;
      logic last;
      logic bnd_lo;
      logic bnd_hi;
   } cell_flags_type;

endpackage

// ===== rtl/core/sle_cell.sv =====
module sle_cell #(
   parameter int CAPACITY    = sle_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = sle_pkg::DEFAULT_VALUE_WIDTH,
   parameter int INDEX       = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sle_pkg::cell_cmd_type           cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]   count,
   input  logic signed [VALUE_WIDTH-1:0]   cmp_key,
   input  logic signed [VALUE_WIDTH-1:0]   cmp_hi,
   input  logic signed [VALUE_WIDTH-1:0]   ins_key,
   input  logic                            left_lt,
   input  logic                            left_le,
   input  logic signed [VALUE_WIDTH-1:0]   left_value,
   input  logic signed [VALUE_WIDTH-1:0]   right_value,
   output logic signed [VALUE_WIDTH-1:0]   value,
   output sle_pkg::cell_flags_type         flags
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic lt_ff, lt_in;
   logic le_ff, le_in;
   logic eq_ff, eq_in;
   logic last_ff, last_in;
   logic valid;

   always_comb begin
      valid    = count > CNT_W'(INDEX);
      value_in = value_ff;
      lt_in    = lt_ff;
      le_in    = le_ff;
      eq_in    = eq_ff;
      last_in  = last_ff;
      unique case (cmd)
         sle_pkg::CELL_CAPTURE: begin
            lt_in   = valid && (value_ff < cmp_key);
            le_in   = valid && (value_ff <= cmp_hi);
            eq_in   = valid && (value_ff == cmp_key);
            last_in = count == CNT_W'(INDEX + 1);
         end
         sle_pkg::CELL_INSERT: begin
            if (!lt_ff) begin
               value_in = left_lt ? ins_key : left_value;
            end
         end
         sle_pkg::CELL_REMOVE: begin
            if (!lt_ff) begin
               value_in = right_value;
            end
         end
         sle_pkg::CELL_SHIFT: begin
            value_in = right_value;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         lt_ff   <= 1'b0;
         le_ff   <= 1'b0;
         eq_ff   <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         lt_ff   <= lt_in;
         le_ff   <= le_in;
         eq_ff   <= eq_in;
         last_ff <= last_in;
      end
   end

   assign value        = value_ff;
   assign flags.lt     = lt_ff;
   assign flags.le     = le_ff;
   assign flags.eq     = eq_ff;
   assign flags.last   = last_ff;
   assign flags.bnd_lo = left_lt && !lt_ff;
   assign flags.bnd_hi = left_le && !le_ff;

endmodule

// ===== rtl/core/sle_ctrl.sv =====
module sle_ctrl #(
   parameter int CAPACITY    = sle_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = sle_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sle_pkg::REQ_TYPE_W-1:0]       req_type,
   input  logic signed [VALUE_WIDTH-1:0]        req_key,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [sle_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                 rsp_found,
   output logic signed [VALUE_WIDTH-1:0]        rsp_largest,
   output logic [$clog2(CAPACITY+1)-1:0]        rsp_range_count,
   output logic [$clog2(CAPACITY+1)-1:0]        rsp_length,
   input  sle_pkg::cell_flags_type              cell_flags [CAPACITY],
   input  logic signed [VALUE_WIDTH-1:0]        cell_value [CAPACITY],
   output sle_pkg::cell_cmd_type                cmd,
   output logic [$clog2(CAPACITY+1)-1:0]        count,
   output logic signed [VALUE_WIDTH-1:0]        ins_key
);

   localparam int CNT_W = $clog2(CAPACITY+1);

   sle_pkg::ctrl_state_type state_ff, state_in;
   logic [sle_pkg::REQ_TYPE_W-1:0] op_ff, op_in;
   logic signed [VALUE_WIDTH-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [CNT_W-1:0]               shift_ff, shift_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sle_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                           found_ff, found_in;
   logic signed [VALUE_WIDTH-1:0]  largest_ff, largest_in;
   logic [CNT_W-1:0]               range_ff, range_in;
   logic [CNT_W-1:0]               length_ff, length_in;

   logic [CAPACITY-1:0]            bnd_lo_vec;
   logic [CNT_W-1:0]               p_lo_enc, p_hi_enc, p_lo, p_hi, range_cnt;
   logic                           any_lo, any_hi, found_any;
   logic signed [VALUE_WIDTH-1:0]  largest;
   logic                           empty, full, rsp_free;

   always_comb begin
      p_lo_enc  = '0;
      p_hi_enc  = '0;
      any_lo    = 1'b0;
      any_hi    = 1'b0;
      found_any = 1'b0;
      largest   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         bnd_lo_vec[i] = cell_flags[i].bnd_lo;
         if (cell_flags[i].bnd_lo) begin
            p_lo_enc = p_lo_enc | CNT_W'(i);
         end
         if (cell_flags[i].bnd_hi) begin
            p_hi_enc = p_hi_enc | CNT_W'(i);
         end
         if (cell_flags[i].last) begin
            largest = largest | cell_value[i];
         end
         any_lo    = any_lo | cell_flags[i].bnd_lo;
         any_hi    = any_hi | cell_flags[i].bnd_hi;
         found_any = found_any | cell_flags[i].eq;
      end
      p_lo      = any_lo ? p_lo_enc : count_ff;
      p_hi      = any_hi ? p_hi_enc : count_ff;
      range_cnt = (p_hi > p_lo) ? p_hi - p_lo : '0;
   end

   always_comb begin
      empty        = count_ff == '0;
      full         = count_ff == CNT_W'(CAPACITY);
      rsp_free     = !rsp_valid_ff || rsp_tready;
      state_in     = state_ff;
      cmd          = sle_pkg::CELL_HOLD;
      req_tready   = 1'b0;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      found_in     = found_ff;
      largest_in   = largest_ff;
      range_in     = range_ff;
      length_in    = length_ff;
      unique case (state_ff)
         sle_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = sle_pkg::CELL_CAPTURE;
               op_in    = req_type;
               key_in   = req_key;
               state_in = sle_pkg::ST_EXEC;
            end
         end
         sle_pkg::ST_EXEC: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               status_in    = sle_pkg::STATUS_OK;
               found_in     = 1'b0;
               largest_in   = '0;
               range_in     = '0;
               state_in     = sle_pkg::ST_IDLE;
               unique case (op_ff)
                  sle_pkg::OP_INSERT: begin
                     if (full) begin
                        status_in = sle_pkg::STATUS_FULL;
                     end else begin
                        cmd      = sle_pkg::CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  sle_pkg::OP_DELETE: begin
                     if (empty) begin
                        status_in = sle_pkg::STATUS_EMPTY;
                     end else if (!found_any) begin
                        status_in = sle_pkg::STATUS_NOT_FOUND;
                     end else begin
                        found_in = 1'b1;
                        cmd      = sle_pkg::CELL_REMOVE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  sle_pkg::OP_SEARCH: begin
                     if (empty) begin
                        status_in = sle_pkg::STATUS_EMPTY;
                     end else if (found_any) begin
                        found_in = 1'b1;
                     end else begin
                        status_in = sle_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  sle_pkg::OP_DEL_SMALLER: begin
                     if (empty) begin
                        status_in = sle_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - p_lo;
                        if (p_lo != '0) begin
                           shift_in = p_lo;
                           state_in = sle_pkg::ST_SHIFT;
                        end
                     end
                  end
                  sle_pkg::OP_COUNT_RANGE: begin
                     if (empty) begin
                        status_in = sle_pkg::STATUS_EMPTY;
                     end else begin
                        range_in = range_cnt;
                     end
                  end
                  sle_pkg::OP_LARGEST: begin
                     if (empty) begin
                        status_in = sle_pkg::STATUS_EMPTY;
                     end else begin
                        largest_in = largest;
                     end
                  end
                  default: begin
                  end
               endcase
               length_in = count_in;
            end
         end
         sle_pkg::ST_SHIFT: begin
            cmd      = sle_pkg::CELL_SHIFT;
            shift_in = shift_ff - 1'b1;
            if (shift_ff == CNT_W'(1)) begin
               state_in = sle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      largest_ff <= largest_in;
      range_ff   <= range_in;
      length_ff  <= length_in;
      if (reset) begin
         state_ff     <= sle_pkg::ST_IDLE;
         count_ff     <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_largest     = largest_ff;
   assign rsp_range_count = range_ff;
   assign rsp_length      = length_ff;
   assign count           = count_ff;
   assign ins_key         = key_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == sle_pkg::ST_EXEC)
      else $error("accepted beat not followed by execute");

   a_shift_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == sle_pkg::ST_SHIFT |-> shift_ff != '0)
      else $error("shift state with zero remaining");

   a_sorted_boundary: assert property (@(posedge clock) disable iff (reset)
      state_ff == sle_pkg::ST_EXEC |-> $onehot0(bnd_lo_vec))
      else $error("list order broken: more than one key boundary");

   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sle_pkg::ST_SHIFT && shift_ff == CNT_W'(1)) |=>
         state_ff == sle_pkg::ST_IDLE)
      else $error("shift sequence did not end");

endmodule

// ===== rtl/core/sorted_list_engine_top.sv =====
// Ascending list of up to CAPACITY signed values held in a row of cells, one value per
// cell. A request beat is taken only while the block is idle; the accept edge has every
// cell compare its value against the key and upper bound, and the execute state then moves the
// cells by one place for insert or delete and loads the result register. Delete-smaller then
// shifts the whole row left one place per cycle, until every dropped entry is gone. If the
// previous result has not been taken, the execute cycle waits for it. Requests may be accepted
// while a result still waits on the output.
module sorted_list_engine_top #(
   parameter int CAPACITY    = sle_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = sle_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // key_value, upper_bound
   input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]           req_tdata,
   // req_type
   input  logic [sle_pkg::REQ_TYPE_W-1:0]               req_tuser,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // status, found, largest_value, range_count, list_length
   output logic [((3+VALUE_WIDTH+2*$clog2(CAPACITY+1)+7)/8)*8-1:0] rsp_tdata
);

   localparam int CNT_W      = $clog2(CAPACITY+1);
   localparam int RSP_DATA_W = ((3+VALUE_WIDTH+2*CNT_W+7)/8)*8;
   localparam int RSP_BITS   = 3 + VALUE_WIDTH + 2*CNT_W;

   logic signed [VALUE_WIDTH-1:0]  req_key, req_hi;
   sle_pkg::cell_flags_type        cell_flags [CAPACITY];
   logic signed [VALUE_WIDTH-1:0]  cell_value [CAPACITY];
   logic                           left_lt [CAPACITY];
   logic                           left_le [CAPACITY];
   logic signed [VALUE_WIDTH-1:0]  left_value [CAPACITY];
   logic signed [VALUE_WIDTH-1:0]  right_value [CAPACITY];
   sle_pkg::cell_cmd_type          cmd;
   logic [CNT_W-1:0]               count;
   logic signed [VALUE_WIDTH-1:0]  ins_key;
   logic [sle_pkg::STATUS_W-1:0]   rsp_status;
   logic                           rsp_found;
   logic signed [VALUE_WIDTH-1:0]  rsp_largest;
   logic [CNT_W-1:0]               rsp_range_count;
   logic [CNT_W-1:0]               rsp_length;
   logic [RSP_BITS-1:0]            rsp_bits;

   assign req_key = req_tdata[VALUE_WIDTH-1:0];
   assign req_hi  = req_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_lt[g]    = 1'b1;
         assign left_le[g]    = 1'b1;
         assign left_value[g] = ins_key;
      end else begin : g_body
         assign left_lt[g]    = cell_flags[g-1].lt;
         assign left_le[g]    = cell_flags[g-1].le;
         assign left_value[g] = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_value[g] = cell_value[g];
      end else begin : g_inner
         assign right_value[g] = cell_value[g+1];
      end

      sle_cell #(
         .CAPACITY    (CAPACITY),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .count       (count),
         .cmp_key     (req_key),
         .cmp_hi      (req_hi),
         .ins_key     (ins_key),
         .left_lt     (left_lt[g]),
         .left_le     (left_le[g]),
         .left_value  (left_value[g]),
         .right_value (right_value[g]),
         .value       (cell_value[g]),
         .flags       (cell_flags[g])
      );
   end

   sle_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_type        (req_tuser),
      .req_key         (req_key),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_largest     (rsp_largest),
      .rsp_range_count (rsp_range_count),
      .rsp_length      (rsp_length),
      .cell_flags      (cell_flags),
      .cell_value      (cell_value),
      .cmd             (cmd),
      .count           (count),
      .ins_key         (ins_key)
   );

   assign rsp_bits  = {rsp_length, rsp_range_count, rsp_largest, rsp_found, rsp_status};
   assign rsp_tdata = RSP_DATA_W'(rsp_bits);

endmodule
